### src/shape_pair_collision_test_top_defines.svh
// Assertion helpers used by the RTL.
`ifndef SHAPE_PAIR_COLLISION_TEST_TOP_DEFINES_SVH
`define SHAPE_PAIR_COLLISION_TEST_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SPCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spct assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SPCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spct assertion failed");

`endif

### src/spct_pkg.sv
`timescale 1ns / 1ps

package spct_pkg;

  localparam int SIZE_W = 15;
  localparam int MAG_W  = 17;
  localparam int SQ_W   = 2 * MAG_W;

  localparam logic [1:0] ACT_RECT_RECT     = 2'd0;
  localparam logic [1:0] ACT_CIRCLE_CIRCLE = 2'd1;
  localparam logic [1:0] ACT_RECT_CIRCLE   = 2'd2;
  localparam logic [1:0] ACT_RESERVED      = 2'd3;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [SQ_W-1:0]  sq_t;

  typedef struct packed {
    mag_t dx;
    mag_t dy;
    logic near;
  } corner_t;

endpackage

### src/spct_corner.sv
`timescale 1ns / 1ps

module spct_corner (
  input  logic              clk,
  input  logic              en,
  input  spct_pkg::corner_t corner,
  input  spct_pkg::sq_t     rr2,
  output logic              ok
);

  spct_pkg::sq_t sq_x_r;
  spct_pkg::sq_t sq_y_r;
  logic          near_r;
  logic [spct_pkg::SQ_W:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r <= corner.dx * corner.dx;
      sq_y_r <= corner.dy * corner.dy;
      near_r <= corner.near;
    end
  end

  assign sum = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign ok  = near_r && (sum <= {1'b0, rr2});

endmodule

### src/shape_pair_collision_test_top.sv
`timescale 1ns / 1ps
// Shape pair collision test.
// Input channel (in_valid / in_ready) carries one word per shape pair: the
// pair selector in_action and the centres and sizes of both shapes.
// Output channel (out_valid / out_ready) returns one word per input word:
// out_hit when the shapes overlap or touch, out_invalid for the reserved
// selector. Results leave in the order the pairs arrived.
// A new pair is accepted every cycle while the output is not stalled, so the
// throughput is one word per cycle. The four register stages are the offsets,
// magnitude compares, squaring multipliers and the square-sum compare into the
// output register.
// Each stage has its own valid bit and takes a new word whenever it is empty
// or its successor moves, so bubbles are squeezed out and a word waiting at
// the output does not block input until every stage is full.
// When the receiver holds out_ready low, out_valid and the result stay put.
// Reset clears all valid bits; no word is in flight after reset.
`include "shape_pair_collision_test_top_defines.svh"

module shape_pair_collision_test_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_action,
  input  logic signed [COORD_BITS-1:0]       in_a_x,
  input  logic signed [COORD_BITS-1:0]       in_a_y,
  input  logic [spct_pkg::SIZE_W-1:0]        in_a_width,
  input  logic [spct_pkg::SIZE_W-1:0]        in_a_height,
  input  logic [spct_pkg::SIZE_W-1:0]        in_a_radius,
  input  logic signed [COORD_BITS-1:0]       in_b_x,
  input  logic signed [COORD_BITS-1:0]       in_b_y,
  input  logic [spct_pkg::SIZE_W-1:0]        in_b_width,
  input  logic [spct_pkg::SIZE_W-1:0]        in_b_height,
  input  logic [spct_pkg::SIZE_W-1:0]        in_b_radius,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic                               out_invalid
);

  localparam int DW = ((COORD_BITS > spct_pkg::SIZE_W) ? COORD_BITS : spct_pkg::SIZE_W) + 4;
  localparam int MW = spct_pkg::MAG_W;
  localparam int SW = spct_pkg::SIZE_W;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) out_valid <= v3_r;
    end
  end

  // Stage 1: doubled offsets from the circle centre to the rectangle edges, or doubled centre offsets for circle pairs.
  logic signed [DW-1:0] ax_e, ay_e, bx_e, by_e, aw_e, ah_e;
  logic signed [DW-1:0] ex, ey;
  logic signed [DW-1:0] dl_nxt, dr_nxt, dt_nxt, db_nxt;
  logic [MW-1:0]        rr_nxt;
  logic [SW:0]          sx_nxt, sy_nxt;

  assign ax_e = DW'(in_a_x);
  assign ay_e = DW'(in_a_y);
  assign bx_e = DW'(in_b_x);
  assign by_e = DW'(in_b_y);
  assign aw_e = DW'($signed({1'b0, in_a_width}));
  assign ah_e = DW'($signed({1'b0, in_a_height}));
  assign ex   = (ax_e - bx_e) <<< 1;
  assign ey   = (ay_e - by_e) <<< 1;
  assign sx_nxt = {1'b0, in_a_width} + {1'b0, in_b_width};
  assign sy_nxt = {1'b0, in_a_height} + {1'b0, in_b_height};

  always_comb begin
    if (in_action == spct_pkg::ACT_CIRCLE_CIRCLE) begin
      dl_nxt = ex;
      dr_nxt = ex;
      dt_nxt = ey;
      db_nxt = ey;
      rr_nxt = {({1'b0, in_a_radius} + {1'b0, in_b_radius}), 1'b0};
    end else begin
      dl_nxt = ex - aw_e;
      dr_nxt = ex + aw_e;
      dt_nxt = ey - ah_e;
      db_nxt = ey + ah_e;
      rr_nxt = {1'b0, in_b_radius, 1'b0};
    end
  end

  logic signed [DW-1:0] dl_r, dr_r, dt_r, db_r, ex_r, ey_r;
  logic [MW-1:0]        rr1_r;
  logic [SW:0]          sx_r, sy_r;
  logic [1:0]           act1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dl_r   <= dl_nxt;
      dr_r   <= dr_nxt;
      dt_r   <= dt_nxt;
      db_r   <= db_nxt;
      ex_r   <= ex;
      ey_r   <= ey;
      rr1_r  <= rr_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
      act1_r <= in_action;
    end
  end

  // Stage 2: magnitudes, range compares, inside and edge tests.
  logic [DW-1:0]        ml, mr, mt, mb, mex, mey, rr_e;
  logic                 le_l, le_r, le_t, le_b;
  logic                 hin, vin, center_in, edge_hit, rect_hit;
  logic signed [DW:0]   sum_x, sum_y;
  spct_pkg::corner_t    c_nxt [4];

  assign ml   = $unsigned(dl_r[DW-1] ? -dl_r : dl_r);
  assign mr   = $unsigned(dr_r[DW-1] ? -dr_r : dr_r);
  assign mt   = $unsigned(dt_r[DW-1] ? -dt_r : dt_r);
  assign mb   = $unsigned(db_r[DW-1] ? -db_r : db_r);
  assign mex  = $unsigned(ex_r[DW-1] ? -ex_r : ex_r);
  assign mey  = $unsigned(ey_r[DW-1] ? -ey_r : ey_r);
  assign rr_e = DW'(rr1_r);
  assign le_l = ml <= rr_e;
  assign le_r = mr <= rr_e;
  assign le_t = mt <= rr_e;
  assign le_b = mb <= rr_e;
  assign hin  = (dl_r <= 0) && (dr_r >= 0);
  assign vin  = (dt_r <= 0) && (db_r >= 0);
  assign sum_x = (DW+1)'(dl_r) + (DW+1)'(dr_r);
  assign sum_y = (DW+1)'(dt_r) + (DW+1)'(db_r);
  assign center_in = hin && vin;
  assign edge_hit = (hin && (sum_y >= 0) && le_t) || (hin && (sum_y <= 0) && le_b) ||
                    (vin && (sum_x >= 0) && le_l) || (vin && (sum_x <= 0) && le_r);
  assign rect_hit = (mex <= DW'(sx_r)) && (mey <= DW'(sy_r));

  assign c_nxt[0] = '{dx: ml[MW-1:0], dy: mt[MW-1:0], near: le_l && le_t};
  assign c_nxt[1] = '{dx: mr[MW-1:0], dy: mt[MW-1:0], near: le_r && le_t};
  assign c_nxt[2] = '{dx: ml[MW-1:0], dy: mb[MW-1:0], near: le_l && le_b};
  assign c_nxt[3] = '{dx: mr[MW-1:0], dy: mb[MW-1:0], near: le_r && le_b};

  spct_pkg::corner_t c_r [4];
  logic [MW-1:0]     rr2_r;
  logic [1:0]        act2_r;
  logic              early2_r, rect2_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      c_r      <= c_nxt;
      rr2_r    <= rr1_r;
      act2_r   <= act1_r;
      early2_r <= center_in || edge_hit;
      rect2_r  <= rect_hit;
    end
  end

  // Stage 3: squares inside the corner units, squared radius here.
  spct_pkg::sq_t rsq_r;
  logic [1:0]    act3_r;
  logic          early3_r, rect3_r;
  logic [3:0]    corner_ok;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      rsq_r    <= rr2_r * rr2_r;
      act3_r   <= act2_r;
      early3_r <= early2_r;
      rect3_r  <= rect2_r;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_corner
    spct_corner u_corner (
      .clk    (clk),
      .en     (rdy3),
      .corner (c_r[g]),
      .rr2    (rsq_r),
      .ok     (corner_ok[g])
    );
  end

  // Stage 4: result selection into the output register.
  logic hit_nxt, invalid_nxt;

  always_comb begin
    invalid_nxt = 1'b0;
    unique case (act3_r)
      spct_pkg::ACT_RECT_RECT:     hit_nxt = rect3_r;
      spct_pkg::ACT_CIRCLE_CIRCLE: hit_nxt = corner_ok[0];
      spct_pkg::ACT_RECT_CIRCLE:   hit_nxt = early3_r || (|corner_ok);
      spct_pkg::ACT_RESERVED: begin
        hit_nxt     = 1'b0;
        invalid_nxt = 1'b1;
      end
      default: hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_hit     <= hit_nxt;
      out_invalid <= invalid_nxt;
    end
  end

  `SPCT_ASSERT_IMP(a_invalid_no_hit, clk, rst_n, out_valid && out_invalid, !out_hit)
  `SPCT_ASSERT_IMP(a_empty_ready, clk, rst_n, !v1_r && !v2_r && !v3_r && !out_valid, in_ready)
  `SPCT_ASSERT_NXT(a_stage3_hold, clk, rst_n, v3_r && !rdy4, v3_r)

endmodule
